// ===== src/segment_intersection_2d_core_macros.svh =====
`ifndef SEGMENT_INTERSECTION_2D_CORE_MACROS_SVH
`define SEGMENT_INTERSECTION_2D_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define SI2D_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SI2D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/si2d_pkg.sv =====
package si2d_pkg;

  localparam int COORD_W = 20;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int MAG_W   = PROD_W;
  localparam int LO_W    = MAG_W / 2;
  localparam int HI_W    = MAG_W - LO_W;
  localparam int PP_LO_W = LO_W + COORD_W;
  localparam int PP_HI_W = HI_W + COORD_W;
  localparam int N_W     = MAG_W + COORD_W;
  localparam int Q_W     = COORD_W;
  localparam int CELLS   = Q_W;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_start_x;
    logic signed [COORD_W-1:0] a_start_y;
    logic signed [COORD_W-1:0] a_end_x;
    logic signed [COORD_W-1:0] a_end_y;
    logic signed [COORD_W-1:0] b_start_x;
    logic signed [COORD_W-1:0] b_start_y;
    logic signed [COORD_W-1:0] b_end_x;
    logic signed [COORD_W-1:0] b_end_y;
  } seg_t;

  typedef struct packed {
    logic                      hit;
    logic                      parallel;
    logic signed [COORD_W-1:0] cross_x;
    logic signed [COORD_W-1:0] cross_y;
  } pt_t;

  typedef struct packed {
    logic [N_W-1:0] rem;
    logic [Q_W-1:0] q;
    logic           neg;
  } lane_t;

  typedef struct packed {
    logic                      hit;
    logic                      parallel;
    logic signed [COORD_W-1:0] a_start_x;
    logic signed [COORD_W-1:0] a_start_y;
    logic [N_W-1:0]            dsh;
    lane_t                     x;
    lane_t                     y;
  } div_t;

  // one restoring step: subtract the shifted divisor when it fits
  function automatic lane_t lane_step(input lane_t l, input logic [N_W-1:0] dsh);
    lane_t        r;
    logic [N_W:0] diff;
    begin
      diff = {1'b0, l.rem} - {1'b0, dsh};
      r = l;
      if (!diff[N_W]) r.rem = diff[N_W-1:0];
      r.q = {l.q[Q_W-2:0], ~diff[N_W]};
      return r;
    end
  endfunction

endpackage

// ===== src/si2d_setup.sv =====
module si2d_setup
  import si2d_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic seg_valid,
  input  seg_t seg,
  output logic head_valid,
  output div_t head
);

  // stage 1: differences
  logic                      v1;
  logic signed [DIFF_W-1:0]  dax1, day1, dbx1, dby1, wx1, wy1;
  logic signed [COORD_W-1:0] ax1, ay1;
  // stage 2: products
  logic                      v2;
  logic signed [PROD_W-1:0]  pd1, pd2, ps1, ps2, pt1, pt2;
  logic signed [DIFF_W-1:0]  dax2, day2;
  logic signed [COORD_W-1:0] ax2, ay2;
  // stage 3: cross products
  logic                      v3;
  logic signed [SUM_W-1:0]   den3, sn3, tn3;
  logic signed [DIFF_W-1:0]  dax3, day3;
  logic signed [COORD_W-1:0] ax3, ay3;
  // stage 4: range test and magnitudes
  logic                      v4, hit4, par4, nx4, ny4;
  logic [MAG_W-1:0]          den4, tn4;
  logic [COORD_W-1:0]        mx4, my4;
  logic signed [COORD_W-1:0] ax4, ay4;
  // stage 5: partial products
  logic                      v5, hit5, par5, nx5, ny5;
  logic [MAG_W-1:0]          den5;
  logic [PP_LO_W-1:0]        xlo5, ylo5;
  logic [PP_HI_W-1:0]        xhi5, yhi5;
  logic signed [COORD_W-1:0] ax5, ay5;

  logic                      neg3, sok3, tok3;
  logic signed [SUM_W-1:0]   den_abs3, tn_abs3;
  logic signed [DIFF_W-1:0]  mx_abs3, my_abs3;

  always_comb begin
    neg3     = den3[SUM_W-1];
    sok3     = neg3 ? (sn3 <= 0 && sn3 >= den3) : (sn3 >= 0 && sn3 <= den3);
    tok3     = neg3 ? (tn3 <= 0 && tn3 >= den3) : (tn3 >= 0 && tn3 <= den3);
    den_abs3 = neg3 ? -den3 : den3;
    tn_abs3  = neg3 ? -tn3 : tn3;
    mx_abs3  = dax3[DIFF_W-1] ? -dax3 : dax3;
    my_abs3  = day3[DIFF_W-1] ? -day3 : day3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      head_valid <= 1'b0;
    end else if (en) begin
      v1 <= seg_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      head_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dax1 <= {seg.a_end_x[COORD_W-1], seg.a_end_x} - {seg.a_start_x[COORD_W-1], seg.a_start_x};
      day1 <= {seg.a_end_y[COORD_W-1], seg.a_end_y} - {seg.a_start_y[COORD_W-1], seg.a_start_y};
      dbx1 <= {seg.b_end_x[COORD_W-1], seg.b_end_x} - {seg.b_start_x[COORD_W-1], seg.b_start_x};
      dby1 <= {seg.b_end_y[COORD_W-1], seg.b_end_y} - {seg.b_start_y[COORD_W-1], seg.b_start_y};
      wx1  <= {seg.a_start_x[COORD_W-1], seg.a_start_x}
              - {seg.b_start_x[COORD_W-1], seg.b_start_x};
      wy1  <= {seg.a_start_y[COORD_W-1], seg.a_start_y}
              - {seg.b_start_y[COORD_W-1], seg.b_start_y};
      ax1  <= seg.a_start_x;
      ay1  <= seg.a_start_y;

      pd1  <= dax1 * dby1;
      pd2  <= dbx1 * day1;
      ps1  <= dax1 * wy1;
      ps2  <= day1 * wx1;
      pt1  <= dbx1 * wy1;
      pt2  <= dby1 * wx1;
      dax2 <= dax1;
      day2 <= day1;
      ax2  <= ax1;
      ay2  <= ay1;

      den3 <= SUM_W'(pd1) - SUM_W'(pd2);
      sn3  <= SUM_W'(ps1) - SUM_W'(ps2);
      tn3  <= SUM_W'(pt1) - SUM_W'(pt2);
      dax3 <= dax2;
      day3 <= day2;
      ax3  <= ax2;
      ay3  <= ay2;

      par4 <= (den3 == '0);
      hit4 <= (den3 != '0) && sok3 && tok3;
      den4 <= den_abs3[MAG_W-1:0];
      tn4  <= tn_abs3[MAG_W-1:0];
      mx4  <= mx_abs3[COORD_W-1:0];
      my4  <= my_abs3[COORD_W-1:0];
      nx4  <= dax3[DIFF_W-1];
      ny4  <= day3[DIFF_W-1];
      ax4  <= ax3;
      ay4  <= ay3;

      xlo5 <= PP_LO_W'(tn4[LO_W-1:0]) * PP_LO_W'(mx4);
      ylo5 <= PP_LO_W'(tn4[LO_W-1:0]) * PP_LO_W'(my4);
      xhi5 <= PP_HI_W'(tn4[MAG_W-1:LO_W]) * PP_HI_W'(mx4);
      yhi5 <= PP_HI_W'(tn4[MAG_W-1:LO_W]) * PP_HI_W'(my4);
      den5 <= den4;
      hit5 <= hit4;
      par5 <= par4;
      nx5  <= nx4;
      ny5  <= ny4;
      ax5  <= ax4;
      ay5  <= ay4;

      head.hit       <= hit5;
      head.parallel  <= par5;
      head.a_start_x <= ax5;
      head.a_start_y <= ay5;
      head.dsh       <= N_W'(den5) << (Q_W - 1);
      head.x.rem     <= (N_W'(xhi5) << LO_W) + N_W'(xlo5);
      head.y.rem     <= (N_W'(yhi5) << LO_W) + N_W'(ylo5);
      head.x.q       <= '0;
      head.y.q       <= '0;
      head.x.neg     <= nx5;
      head.y.neg     <= ny5;
    end
  end

endmodule

// ===== src/si2d_div_cell.sv =====
module si2d_div_cell
  import si2d_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic prev_valid,
  input  div_t prev,
  output logic next_valid,
  output div_t next
);

  div_t step;

  always_comb begin
    step     = prev;
    step.x   = lane_step(prev.x, prev.dsh);
    step.y   = lane_step(prev.y, prev.dsh);
    step.dsh = prev.dsh >> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_valid <= 1'b0;
    end else if (en) begin
      next_valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) next <= step;
  end

endmodule

// ===== src/si2d_skid.sv =====
module si2d_skid
  import si2d_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic res_valid,
  input  pt_t  res,
  output logic full,
  output logic pt_valid,
  input  logic pt_stall,
  output pt_t  pt
);

  pt_t spare;

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_valid <= 1'b0;
      full     <= 1'b0;
    end else if (pt_valid && pt_stall) begin
      if (res_valid && !full) full <= 1'b1;
    end else if (full) begin
      pt_valid <= 1'b1;
      full     <= 1'b0;
    end else begin
      pt_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pt_valid && pt_stall) begin
      if (res_valid && !full) spare <= res;
    end else begin
      pt <= full ? spare : res;
    end
  end

endmodule

// ===== src/segment_intersection_2d_core.sv =====
// path from an accepted transaction to pt_valid: 6 setup stages,
// one divider cell per quotient bit, one output register
// throughput: one transaction per cycle while seg_stall is low; the divider chain is fully pipelined
// a one-entry skid buffer behind the output register holds the chain on stall
// reset: synchronous rst clears all valid flags and the skid full flag; no other state
module segment_intersection_2d_core
  import si2d_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic seg_valid,
  output logic seg_stall,
  input  seg_t seg,
  output logic pt_valid,
  input  logic pt_stall,
  output pt_t  pt
);

`include "segment_intersection_2d_core_macros.svh"

  logic                      en, full;
  logic                      vld [CELLS+1];
  div_t                      chain [CELLS+1];
  pt_t                       res;
  logic signed [COORD_W:0]   sx, sy;

  assign en        = !full;
  assign seg_stall = full;

  si2d_setup u_setup (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .seg_valid  (seg_valid),
    .seg        (seg),
    .head_valid (vld[0]),
    .head       (chain[0])
  );

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    si2d_div_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .prev_valid (vld[i]),
      .prev       (chain[i]),
      .next_valid (vld[i+1]),
      .next       (chain[i+1])
    );
  end

  // point = start +/- quotient; it lies on segment A so it fits
  always_comb begin
    sx = chain[CELLS].x.neg
       ? {chain[CELLS].a_start_x[COORD_W-1], chain[CELLS].a_start_x} - {1'b0, chain[CELLS].x.q}
       : {chain[CELLS].a_start_x[COORD_W-1], chain[CELLS].a_start_x} + {1'b0, chain[CELLS].x.q};
    sy = chain[CELLS].y.neg
       ? {chain[CELLS].a_start_y[COORD_W-1], chain[CELLS].a_start_y} - {1'b0, chain[CELLS].y.q}
       : {chain[CELLS].a_start_y[COORD_W-1], chain[CELLS].a_start_y} + {1'b0, chain[CELLS].y.q};
    res.hit      = chain[CELLS].hit;
    res.parallel = chain[CELLS].parallel;
    res.cross_x  = chain[CELLS].hit ? sx[COORD_W-1:0] : '0;
    res.cross_y  = chain[CELLS].hit ? sy[COORD_W-1:0] : '0;
  end

  si2d_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .res_valid (vld[CELLS]),
    .res       (res),
    .full      (full),
    .pt_valid  (pt_valid),
    .pt_stall  (pt_stall),
    .pt        (pt)
  );

  `SI2D_ASSERT_NOW(a_par_no_hit, pt_valid && pt.parallel, !pt.hit, "parallel result flagged as hit")
  `SI2D_ASSERT_NOW(a_miss_zero, pt_valid && !pt.hit, pt.cross_x == '0 && pt.cross_y == '0, "miss with nonzero point")
  `SI2D_ASSERT_NOW(a_skid_behind_out, full, pt_valid, "skid entry without output entry")
  `SI2D_ASSERT_NEXT(a_skid_drains, full && !pt_stall, !full, "skid entry not drained")

endmodule
